>>> src/ir_trigger_frame_transmitter_core_macros.svh
// Assertion macros shared by the checker of the infrared trigger frame transmitter.
`ifndef IR_TRIGGER_FRAME_TRANSMITTER_CORE_MACROS_SVH
`define IR_TRIGGER_FRAME_TRANSMITTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is held.
`define IR_TFT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ir_tft check failed");

// Next-cycle implication, sampled on the rising clock edge, off while reset is held.
`define IR_TFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ir_tft check failed");

`endif

>>> src/ir_tft_pkg.sv
`default_nettype none

package ir_tft_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    REG_CODE_WORD       = 2'd0,
    REG_COOLDOWN_TICKS  = 2'd1,
    REG_BIT_TICKS       = 2'd2,
    REG_CARRIER_COMPARE = 2'd3
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 32;

  // Reset values of the configuration registers.
  localparam logic [15:0] BitTicksRst       = 16'd500;
  localparam logic [7:0]  CarrierCompareRst = 8'd210;

  // Status reported with every result word.
  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_COOLING = 2'd1,
    ST_STARTED = 2'd2,
    ST_SENDING = 2'd3
  } shot_status_e;

  // Frame slots: start, eight code bits, parity, stop.
  localparam logic [3:0] SlotStart  = 4'd0;
  localparam logic [3:0] SlotFirst  = 4'd1;
  localparam logic [3:0] SlotLast   = 4'd8;
  localparam logic [3:0] SlotParity = 4'd9;
  localparam logic [3:0] SlotStop   = 4'd10;

endpackage

`default_nettype wire

>>> src/ir_trigger_frame_transmitter_core.sv
// Infrared trigger frame transmitter.
// One input word per tick of the timing base carries the trigger level on
// button_pressed_i; each accepted word yields exactly one result word with the
// frame envelope, the gated carrier level and a shot status.
// Input and output channels use valid/stall: a word moves on a rising edge with
// valid high and stall low. The result sits in an output register, so it appears
// in the cycle after its word is taken; the block takes one word per cycle while
// the output drains. When the receiver stalls with a result pending, in_stall_o
// rises in the same cycle and all frame state holds until the result is taken.
// Configuration writes use cfg_valid_i/cfg_ready_o with a register index and
// data; cfg_ready_o is always high. The user must make writes only while the block is
// idle, which the block does not enforce. Reset clears the cooldown counter, the frame
// state and the carrier, sets bit_ticks to 500 and carrier_compare to 210 and empties
// the output register. Per tick, the cooldown counter (one 32-bit compare) and the
// slot tick counter (one compare against the slot length) set the critical path.
`default_nettype none

module ir_trigger_frame_transmitter_core
  import ir_tft_pkg::*;
#(
  parameter int unsigned BIT_COUNTER_WIDTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                button_pressed_i,
  // Output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     ir_envelope_o,
  output logic                     ir_carrier_o,
  output logic [1:0]               shot_status_o,
  // Configuration channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW = BIT_COUNTER_WIDTH;
  localparam int unsigned CmpW = 33;
  localparam logic [CmpW-1:0] SlotCap = (CmpW'(1) << CntW) - CmpW'(1);

  // Configuration registers.
  logic [7:0]  code_word_q;
  logic [31:0] cooldown_ticks_q;
  logic [15:0] bit_ticks_q;
  logic [7:0]  carrier_compare_q;

  // Frame state.
  logic [31:0]     cooldown_count_q, cooldown_count_d;
  logic            frame_active_q, frame_active_d;
  logic [3:0]      frame_slot_q, frame_slot_d;
  logic [CntW-1:0] slot_tick_q, slot_tick_d;
  logic [7:0]      shift_bits_q, shift_bits_d;
  logic            parity_q, parity_d;
  logic [7:0]      carrier_div_q, carrier_div_d;
  logic            carrier_q, carrier_d;

  // Output register.
  logic         out_valid_q;
  logic         envelope_q;
  logic [1:0]   status_q;

  logic            in_accept;
  logic            envelope_d;
  shot_status_e    status_d;
  logic [CntW-1:0] slot_tick_inc;
  logic [15:0]     slot_len_raw;
  logic [CmpW-1:0] slot_len;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Configuration writes; unknown indexes fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_word_q       <= '0;
      cooldown_ticks_q  <= '0;
      bit_ticks_q       <= BitTicksRst;
      carrier_compare_q <= CarrierCompareRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CODE_WORD:       code_word_q       <= cfg_data_i[7:0];
        REG_COOLDOWN_TICKS:  cooldown_ticks_q  <= cfg_data_i[31:0];
        REG_BIT_TICKS:       bit_ticks_q       <= cfg_data_i[15:0];
        REG_CARRIER_COMPARE: carrier_compare_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Length of the current slot: half a bit for the start slot, at least one
  // tick, and no more than the slot tick counter can hold.
  always_comb begin
    slot_len_raw = (frame_slot_q == SlotStart) ? {1'b0, bit_ticks_q[15:1]} : bit_ticks_q;
    slot_len     = CmpW'(slot_len_raw);
    if (slot_len_raw == 16'd0) begin
      slot_len = CmpW'(1);
    end
    if (slot_len > SlotCap) begin
      slot_len = SlotCap;
    end
  end

  assign slot_tick_inc = slot_tick_q + CntW'(1);

  // Next frame state, envelope, carrier and status for one tick.
  always_comb begin
    cooldown_count_d = cooldown_count_q;
    frame_active_d   = frame_active_q;
    frame_slot_d     = frame_slot_q;
    slot_tick_d      = slot_tick_q;
    shift_bits_d     = shift_bits_q;
    parity_d         = parity_q;
    carrier_div_d    = carrier_div_q;
    carrier_d        = carrier_q;
    status_d         = ST_IDLE;

    if (!frame_active_q) begin
      if (cooldown_count_q > cooldown_ticks_q) begin
        // Cooldown over: restart the counter and sample the button.
        cooldown_count_d = '0;
        if (button_pressed_i) begin
          frame_active_d = 1'b1;
          frame_slot_d   = SlotStart;
          slot_tick_d    = '0;
          shift_bits_d   = code_word_q;
          parity_d       = 1'b0;
          status_d       = ST_STARTED;
        end
      end else begin
        if (cooldown_count_q != '1) begin
          cooldown_count_d = cooldown_count_q + 32'd1;
        end
        status_d = button_pressed_i ? ST_COOLING : ST_IDLE;
      end
    end else begin
      status_d    = ST_SENDING;
      slot_tick_d = slot_tick_inc;
      if (CmpW'(slot_tick_inc) >= slot_len) begin
        // Slot finished: shift out a code bit if this was a code bit slot, and move on.
        slot_tick_d = '0;
        if (frame_slot_q >= SlotFirst && frame_slot_q <= SlotLast) begin
          parity_d     = parity_q ^ shift_bits_q[7];
          shift_bits_d = {shift_bits_q[6:0], 1'b0};
        end
        if (frame_slot_q >= SlotStop) begin
          frame_active_d = 1'b0;
          frame_slot_d   = SlotStart;
        end else begin
          frame_slot_d = frame_slot_q + 4'd1;
        end
      end
    end

    // Envelope level of the slot the frame is now in.
    if (!frame_active_d) begin
      envelope_d = 1'b0;
    end else if (frame_slot_d == SlotStart || frame_slot_d == SlotStop) begin
      envelope_d = 1'b1;
    end else if (frame_slot_d == SlotParity) begin
      envelope_d = parity_d;
    end else begin
      envelope_d = shift_bits_d[7];
    end

    // Carrier divider runs only while the envelope is high.
    if (envelope_d) begin
      if (carrier_div_q >= carrier_compare_q) begin
        carrier_div_d = '0;
        carrier_d     = !carrier_q;
      end else begin
        carrier_div_d = carrier_div_q + 8'd1;
      end
    end
  end

  // Frame state advances once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_count_q <= '0;
      frame_active_q   <= 1'b0;
      frame_slot_q     <= SlotStart;
      slot_tick_q      <= '0;
      shift_bits_q     <= '0;
      parity_q         <= 1'b0;
      carrier_div_q    <= '0;
      carrier_q        <= 1'b0;
    end else if (in_accept) begin
      cooldown_count_q <= cooldown_count_d;
      frame_active_q   <= frame_active_d;
      frame_slot_q     <= frame_slot_d;
      slot_tick_q      <= slot_tick_d;
      shift_bits_q     <= shift_bits_d;
      parity_q         <= parity_d;
      carrier_div_q    <= carrier_div_d;
      carrier_q        <= carrier_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload; the carrier level is read from the state register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      envelope_q <= envelope_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ir_envelope_o = envelope_q;
  assign ir_carrier_o  = carrier_q;
  assign shot_status_o = status_q;

endmodule

`default_nettype wire

>>> src/ir_tft_checker.sv
`default_nettype none
`include "ir_trigger_frame_transmitter_core_macros.svh"

module ir_tft_checker
  import ir_tft_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       ir_envelope_o,
  input wire logic       ir_carrier_o,
  input wire logic [1:0] shot_status_o
);

  logic       in_take;
  logic       out_take;
  logic       out_outside;
  logic [3:0] out_word;

  // Handshake and result word views shared by the checks below.
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_o && !out_stall_i;
  assign out_outside = (shot_status_o == ST_IDLE) || (shot_status_o == ST_COOLING);
  assign out_word    = {ir_envelope_o, ir_carrier_o, shot_status_o};

  // A frame start word already drives the start level.
  `IR_TFT_ASSERT_IMPL(a_start_envelope, clk_i, rst_ni, out_valid_o && shot_status_o == ST_STARTED, ir_envelope_o)

  // Outside a frame the envelope is low.
  `IR_TFT_ASSERT_IMPL(a_idle_envelope, clk_i, rst_ni, out_valid_o && out_outside, !ir_envelope_o)

  // A stalled result word holds.
  `IR_TFT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word))

  // A word after a frame start continues that frame.
  `IR_TFT_ASSERT_NEXT(a_start_follow, clk_i, rst_ni, out_take && shot_status_o == ST_STARTED && in_take, shot_status_o == ST_SENDING)

endmodule

bind ir_trigger_frame_transmitter_core ir_tft_checker u_ir_tft_checker (.*);

`default_nettype wire

>>> tb/tb_ir_trigger_frame_transmitter_core.sv
`default_nettype none

module tb_ir_trigger_frame_transmitter_core
  import ir_tft_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CntW = 16;
  localparam int unsigned SlotTicksMax = (1 << CntW) - 1;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomItems = 850;
  // Directed button levels, first word at index 0.
  localparam logic [0:9] DirPress = 10'b1011111001;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // One result word as the block reports it.
  typedef struct packed {
    logic         envelope;
    logic         carrier;
    shot_status_e status;
  } shot_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                button_pressed_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                ir_envelope_o;
  logic                ir_carrier_o;
  logic [1:0]          shot_status_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  ir_trigger_frame_transmitter_core #(
    .BIT_COUNTER_WIDTH(CntW)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .button_pressed_i(button_pressed_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ir_envelope_o   (ir_envelope_o),
    .ir_carrier_o    (ir_carrier_o),
    .shot_status_o   (shot_status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Clock with a period of 8 ns.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Predictor copy of the settings, at their reset values.
  logic [7:0]  cfg_code = '0;
  logic [31:0] cfg_cooldown = '0;
  logic [15:0] cfg_bits = BitTicksRst;
  logic [7:0]  cfg_cmp = CarrierCompareRst;

  // Predictor copy of the frame and carrier state.
  logic [31:0]     cooldown_cnt = '0;
  logic            in_frame = 1'b0;
  logic [3:0]      cur_slot = SlotStart;
  logic [CntW-1:0] slot_ticks = '0;
  logic [7:0]      code_shift = '0;
  logic            parity_acc = 1'b0;
  logic [7:0]      carrier_div = '0;
  logic            carrier_lvl = 1'b0;

  logic       press_queue[$];
  shot_word_t shot_expected[$];
  int unsigned mismatches = 0;
  logic        in_taken = 1'b0;

  // Length of a slot in ticks; zero lengths count as one tick.
  function automatic int unsigned slot_len(logic [3:0] slot);
    int unsigned len;
    len = 32'((slot == SlotStart) ? (cfg_bits >> 1) : cfg_bits);
    if (len == 0) len = 1;
    if (len > SlotTicksMax) len = SlotTicksMax;
    return len;
  endfunction

  // Advances the predicted block by one tick and returns its result word.
  function automatic shot_word_t predict_shot(logic pressed);
    shot_word_t w;
    logic env;
    w.status = ST_IDLE;
    if (!in_frame) begin
      if (cooldown_cnt > cfg_cooldown) begin
        cooldown_cnt = '0;
        if (pressed) begin
          in_frame   = 1'b1;
          cur_slot   = SlotStart;
          slot_ticks = '0;
          code_shift = cfg_code;
          parity_acc = 1'b0;
          w.status   = ST_STARTED;
        end
      end else begin
        if (cooldown_cnt != '1) cooldown_cnt = cooldown_cnt + 1;
        w.status = pressed ? ST_COOLING : ST_IDLE;
      end
    end else begin
      w.status = ST_SENDING;
      slot_ticks = slot_ticks + 1'b1;
      if (slot_ticks >= slot_len(cur_slot)) begin
        slot_ticks = '0;
        if (cur_slot >= SlotFirst && cur_slot <= SlotLast) begin
          parity_acc = parity_acc ^ code_shift[7];
          code_shift = code_shift << 1;
        end
        cur_slot = cur_slot + 1'b1;
        if (cur_slot > SlotStop) begin
          in_frame = 1'b0;
          cur_slot = SlotStart;
        end
      end
    end

    // Envelope level of the slot the frame is in now.
    if (!in_frame) begin
      env = 1'b0;
    end else if (cur_slot == SlotStart || cur_slot == SlotStop) begin
      env = 1'b1;
    end else if (cur_slot == SlotParity) begin
      env = parity_acc;
    end else begin
      env = code_shift[7];
    end

    // The carrier only runs while the envelope is high.
    if (env) begin
      if (carrier_div >= cfg_cmp) begin
        carrier_div = '0;
        carrier_lvl = ~carrier_lvl;
      end else begin
        carrier_div = carrier_div + 1'b1;
      end
    end

    w.envelope = env;
    w.carrier  = carrier_lvl;
    return w;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Monitor: checks result words first, then predicts the word just accepted.
  always @(posedge clk_i) begin
    shot_word_t w;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (shot_expected.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, actual env %0b car %0b st %0d",
                   $time, ir_envelope_o, ir_carrier_o, shot_status_o);
        end else begin
          w = shot_expected.pop_front();
          check_field("ir_envelope_o", w.envelope, ir_envelope_o);
          check_field("ir_carrier_o", w.carrier, ir_carrier_o);
          check_field("shot_status_o", w.status, shot_status_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_taken = 1'b1;
        void'(press_queue.pop_front());
        shot_expected.push_back(predict_shot(button_pressed_i));
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    int unsigned cycles;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ir_trigger_frame_transmitter_core regression: fail");
      $finish;
    end
  end

  // Driver: offers queued words in bursts with random gaps, holding a stalled word.
  always @(negedge clk_i) begin
    int unsigned burst_left;
    int unsigned gap_left;
    if (!(in_valid_i && !in_taken)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (press_queue.size() != 0) begin
        in_valid_i <= 1'b1;
        button_pressed_i <= press_queue[0];
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: switches between stall patterns and now and then holds off for a long stretch.
  always @(negedge clk_i) begin
    int unsigned rx_cycle;
    int unsigned hold_left;
    int unsigned mode_left;
    stall_mode_e rx_mode;
    rx_cycle++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_cycle % 400 == 0) begin
      hold_left = $urandom_range(40, 80);
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 150);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_LIGHT:    out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 7);
        default:        out_stall_i <= (rx_cycle % 3 == 0);
      endcase
    end
  end

  // Writes one register and mirrors it into the predictor.
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CODE_WORD:      cfg_code = data[7:0];
      REG_COOLDOWN_TICKS: cfg_cooldown = data;
      REG_BIT_TICKS:      cfg_bits = data[15:0];
      default:            cfg_cmp = data[7:0];
    endcase
  endtask

  task automatic load_settings(logic [7:0] code, logic [31:0] cool, logic [15:0] bits,
                               logic [7:0] cmp);
    write_reg(REG_CODE_WORD, CfgDataW'(code));
    write_reg(REG_COOLDOWN_TICKS, cool);
    write_reg(REG_BIT_TICKS, CfgDataW'(bits));
    write_reg(REG_CARRIER_COMPARE, CfgDataW'(cmp));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued word is in and every expected word is out.
  task automatic wait_drained();
    while (press_queue.size() != 0 || shot_expected.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Stimulus: a directed start, an all-ones frame, then random phases under changing settings.
  initial begin
    int unsigned random_items;
    int unsigned ph;
    int unsigned remaining;
    int unsigned run;
    logic        level;
    logic [7:0]  code;
    logic [31:0] cool;
    logic [15:0] bits;
    logic [7:0]  cmp;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Reset settings: cooling status, an idle sample, cooling again, then a frame start.
    for (int k = 0; k < 10; k++) begin
      press_queue.push_back(DirPress[k]);
    end
    wait_drained();

    // All-ones code, one-tick bits and the fastest carrier over a whole frame.
    load_settings(8'hFF, 32'd0, 16'd1, 8'd0);
    repeat (15) press_queue.push_back(1'b1);
    wait_drained();

    random_items = 0;
    for (ph = 0; random_items < RandomItems; ph++) begin
      remaining = $urandom_range(50, 90);
      code = ($urandom_range(0, 9) == 0) ? 8'h00 :
             ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom());
      cool = $urandom_range(0, 12);
      bits = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 5)) : 16'($urandom_range(6, 12));
      cmp  = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, 3)) : 8'($urandom());
      case (ph)
        0: begin
          code = 8'h00;
          cool = 32'd0;
          bits = 16'd0;
          cmp  = 8'hFF;
        end
        1: begin
          cool = 32'hFFFF_FFFF;
          remaining = 30;
        end
        2: begin
          cool = 32'd2;
          bits = 16'hFFFF;
          cmp  = 8'hFF;
          remaining = 30;
        end
        3: begin
          cool = $urandom();
          remaining = 30;
        end
        default: ;
      endcase
      load_settings(code, cool, bits, cmp);

      // Mostly held presses and releases, with some single-tick noise.
      random_items += remaining;
      while (remaining > 0) begin
        if ($urandom_range(0, 4) == 0) begin
          press_queue.push_back(1'($urandom_range(0, 1)));
          remaining--;
        end else begin
          level = ($urandom_range(0, 9) < 6);
          run = $urandom_range(1, 8);
          while (run > 0 && remaining > 0) begin
            press_queue.push_back(level);
            run--;
            remaining--;
          end
        end
      end
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && shot_expected.size() == 0) begin
      $display("ir_trigger_frame_transmitter_core regression: pass");
    end else begin
      $display("ir_trigger_frame_transmitter_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+src
src/ir_tft_pkg.sv
src/ir_trigger_frame_transmitter_core.sv
src/ir_tft_checker.sv
tb/tb_ir_trigger_frame_transmitter_core.sv
